// ----- rtl/ofr_pkg.sv -----
// Package for the in-order fragment reassembler.
// Holds the word types of both channels, status codes and item kinds.
// No dependencies; the top level and the testbench import it.
package ofr_pkg;

  // Bytes of a fragment header: flags, message id, index, count.
  localparam int HDR_BYTES = 4;

  // Item kinds carried in the kind field.
  localparam logic [1:0] KIND_FRAG  = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_COMPLETE       = 3'd1,
    ST_BAD_HEADER     = 3'd2,
    ST_OUT_OF_ORDER   = 3'd3,
    ST_DUPLICATE      = 3'd4,
    ST_COUNT_MISMATCH = 3'd5,
    ST_OVERSIZED      = 3'd6,
    ST_TIMEOUT        = 3'd7
  } status_t;

  typedef logic [9:0] rlen_t;
  typedef logic [9:0] ridx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        frag_last;
    logic [31:0] now_ms;
    ridx_t       read_index;
  } item_t;

  typedef struct packed {
    status_t    status;
    rlen_t      record_length;
    logic [7:0] read_byte;
  } result_t;

endpackage

// ----- rtl/ofr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Read data updates only when a read is enabled. No dependencies.
module ofr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/in_order_fragment_reassembler.sv -----
// Top level of the in-order fragment reassembler.
// Depends on ofr_pkg for word types and codes, and on ofr_ram for the record store.
//
//   channel   direction  handshake                     word
//   item      in         item_valid / item_stall       ofr_pkg::item_t
//   result    out        result_valid / result_stall   ofr_pkg::result_t
//   timeout   in         timeout_we (no handshake)     timeout_wdata, 32 bit
//
// One item is accepted every cycle while item_stall is low. A result passes through
// the stage that waits for the store's registered read, then the output register.
// Reset is synchronous and clears all bookkeeping; the record store is not cleared
// and holds undefined bytes until they are written.
// item_stall rises only when a result waits in the pipeline stage and another
// waits in the output register while result_stall is high.
module in_order_fragment_reassembler #(
  parameter int MAX_RECORD = 768
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ofr_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output ofr_pkg::result_t  result,
  input  logic              timeout_we,
  input  logic [31:0]       timeout_wdata
);

  import ofr_pkg::*;

  // Address, length and byte-position widths all follow the record size.
  localparam int AW      = $clog2(MAX_RECORD);
  localparam int LW      = $clog2(MAX_RECORD + 1);
  localparam int POS_SAT = MAX_RECORD + HDR_BYTES + 1;
  localparam int PW      = $clog2(POS_SAT + 1);

  // Bookkeeping registers.
  logic [LW-1:0] rec_len, rec_len_next;
  logic [7:0]    open_id, open_id_next;
  logic [7:0]    open_total, open_total_next;
  logic [7:0]    next_idx, next_idx_next;
  logic [LW-1:0] first_size, first_size_next;
  logic [31:0]   start_time, start_time_next;
  logic          assembling, assembling_next;
  logic [PW-1:0] byte_pos, byte_pos_next;
  logic [7:0]    hdr_id, hdr_id_next;
  logic [7:0]    hdr_idx, hdr_idx_next;
  logic [7:0]    hdr_total, hdr_total_next;
  logic [31:0]   timeout_ms;

  // Pipeline stage that waits for the store's read data, then the output register.
  logic          s1_valid;
  status_t       s1_status;
  logic [LW-1:0] s1_rlen;
  logic          s1_rd_hit;
  logic          out_valid;
  result_t       out_word;

  // Per-item results from the update logic.
  logic          accept;
  logic          s1_adv;
  logic          has_res;
  status_t       res_status;
  logic [LW-1:0] res_rlen;
  logic          rd_hit;

  // Record store ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Fragment arithmetic.
  logic [PW-1:0]   pos_inc;
  logic [PW-1:0]   plen;
  logic [PW-1:0]   pay_off;
  logic [PW:0]     waddr_full;
  logic [PW:0]     len_sum;
  logic [PW+7:0]   span;
  logic            continuing;
  logic [31:0]     age;

  // The handshake: a new item may enter unless both result slots are full and held.
  assign item_stall   = s1_valid && out_valid && result_stall;
  assign accept       = item_valid && !item_stall;
  assign s1_adv       = s1_valid && (!out_valid || !result_stall);
  assign result_valid = out_valid;
  assign result       = out_word;

  // Byte count of the current fragment including this byte, saturating.
  assign pos_inc = (32'(byte_pos) < POS_SAT) ? byte_pos + PW'(1) : PW'(POS_SAT);
  assign plen    = pos_inc - PW'(HDR_BYTES);
  assign pay_off = byte_pos - PW'(HDR_BYTES);
  // Combined payload of all later fragments if every one matches the first one.
  assign span    = (PW + 8)'((hdr_total_next - 8'd1) * plen);
  assign len_sum = (PW + 1)'(rec_len) + (PW + 1)'(plen);
  assign age     = item.now_ms - start_time;

  // A header continues the open message when the ids agree. The id byte is
  // taken from this item when it is the id byte itself.
  assign continuing = assembling && (hdr_id_next == open_id);
  assign waddr_full = (PW + 1)'(continuing ? rec_len : '0) + (PW + 1)'(pay_off);

  assign ram_waddr = AW'(waddr_full);
  assign ram_raddr = AW'(item.read_index);

  always_comb begin
    logic          ok;
    logic          clear;
    logic [7:0]    chk_next;
    logic [7:0]    chk_total;
    logic [LW-1:0] new_len;

    ok        = 1'b0;
    clear     = 1'b0;
    chk_next  = next_idx;
    chk_total = open_total;
    new_len   = rec_len;

    rec_len_next    = rec_len;
    open_id_next    = open_id;
    open_total_next = open_total;
    next_idx_next   = next_idx;
    first_size_next = first_size;
    start_time_next = start_time;
    assembling_next = assembling;
    byte_pos_next   = byte_pos;
    hdr_id_next     = hdr_id;
    hdr_idx_next    = hdr_idx;
    hdr_total_next  = hdr_total;

    has_res    = 1'b0;
    res_status = ST_OK;
    res_rlen   = '0;
    rd_hit     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    // Header bytes are captured in the same cycle they arrive.
    if (item.kind == KIND_FRAG) begin
      if (byte_pos == PW'(1)) begin
        hdr_id_next = item.data_byte;
      end
      if (byte_pos == PW'(2)) begin
        hdr_idx_next = item.data_byte;
      end
      if (byte_pos == PW'(3)) begin
        hdr_total_next = item.data_byte;
      end
    end

    if (accept) begin
      case (item.kind)
        KIND_FRAG: begin
          // Payload bytes go straight into the store; writes past the end drop.
          ram_we = (32'(byte_pos) >= HDR_BYTES) && (32'(waddr_full) < MAX_RECORD);
          if (!item.frag_last) begin
            byte_pos_next = pos_inc;
          end else begin
            byte_pos_next = '0;
            has_res       = 1'b1;
            if (32'(pos_inc) < HDR_BYTES) begin
              res_status = ST_BAD_HEADER;
            end else if (hdr_total_next == 8'd0 || hdr_idx_next >= hdr_total_next) begin
              res_status = ST_BAD_HEADER;
            end else if (!continuing) begin
              // First fragment of a new message.
              if (hdr_idx_next != 8'd0) begin
                res_status = ST_OUT_OF_ORDER;
              end else if (32'(plen) > MAX_RECORD || 32'(span) >= MAX_RECORD) begin
                res_status = ST_OVERSIZED;
              end else begin
                ok              = 1'b1;
                new_len         = LW'(plen);
                open_id_next    = hdr_id_next;
                open_total_next = hdr_total_next;
                first_size_next = LW'(plen);
                start_time_next = item.now_ms;
                assembling_next = 1'b1;
                chk_next        = 8'd1;
                chk_total       = hdr_total_next;
              end
            end else begin
              if (hdr_idx_next < next_idx) begin
                res_status = ST_DUPLICATE;
              end else if (hdr_idx_next > next_idx) begin
                res_status = ST_OUT_OF_ORDER;
              end else if (hdr_total_next != open_total) begin
                res_status = ST_COUNT_MISMATCH;
              end else if (32'(plen) > 32'(first_size)) begin
                res_status = ST_OVERSIZED;
              end else if (32'(len_sum) > MAX_RECORD) begin
                res_status = ST_OVERSIZED;
              end else begin
                ok       = 1'b1;
                new_len  = LW'(len_sum);
                chk_next = hdr_idx_next + 8'd1;
              end
            end

            if (!ok) begin
              clear = 1'b1;
            end else if (chk_next == chk_total) begin
              // Last fragment of the message: report the length and close it.
              res_status = ST_COMPLETE;
              res_rlen   = new_len;
              clear      = 1'b1;
            end else begin
              res_status    = ST_OK;
              rec_len_next  = new_len;
              next_idx_next = chk_next;
            end
          end
        end
        KIND_CHECK: begin
          has_res = 1'b1;
          if (assembling && (age > timeout_ms)) begin
            res_status = ST_TIMEOUT;
            clear      = 1'b1;
          end
        end
        KIND_READ: begin
          has_res = 1'b1;
          rd_hit  = 32'(item.read_index) < MAX_RECORD;
          ram_re  = rd_hit;
        end
        default: begin
          // Unused kind: dropped with no result.
        end
      endcase
    end

    if (clear) begin
      rec_len_next    = '0;
      open_id_next    = '0;
      open_total_next = '0;
      next_idx_next   = '0;
      first_size_next = '0;
      start_time_next = '0;
      assembling_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_len    <= '0;
      open_id    <= '0;
      open_total <= '0;
      next_idx   <= '0;
      first_size <= '0;
      start_time <= '0;
      assembling <= 1'b0;
      byte_pos   <= '0;
      hdr_id     <= '0;
      hdr_idx    <= '0;
      hdr_total  <= '0;
    end else if (accept) begin
      rec_len    <= rec_len_next;
      open_id    <= open_id_next;
      open_total <= open_total_next;
      next_idx   <= next_idx_next;
      first_size <= first_size_next;
      start_time <= start_time_next;
      assembling <= assembling_next;
      byte_pos   <= byte_pos_next;
      hdr_id     <= hdr_id_next;
      hdr_idx    <= hdr_idx_next;
      hdr_total  <= hdr_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= 32'd5000;
    end else if (timeout_we) begin
      timeout_ms <= timeout_wdata;
    end
  end

  // Stage one holds a result while the store's read data comes back.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= has_res;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= res_status;
      s1_rlen   <= res_rlen;
      s1_rd_hit <= rd_hit;
    end
  end

  // The output register takes the stage-one result together with the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!result_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word.status        <= s1_status;
      out_word.record_length <= rlen_t'(s1_rlen);
      out_word.read_byte     <= s1_rd_hit ? ram_rdata : 8'd0;
    end
  end

  ofr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RECORD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- tb/sv/in_order_fragment_reassembler_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the in-order fragment reassembler.
// Depends on ofr_pkg for the word types and status codes, and on the block's RTL.
module in_order_fragment_reassembler_tb;
  import ofr_pkg::*;

  // Record store depth of the block under test, and the value at which the
  // per-fragment byte counter stops counting.
  localparam int REC_MAX = 768;
  localparam int POS_SAT = REC_MAX + HDR_BYTES + 1;

  // The fourth item kind has no meaning; the block drops such words silently.
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // Cycles in which no word moves on either channel before the run is abandoned.
  // The longest legal quiet stretch is a sender gap plus a receiver stall, so this
  // leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  // This pad covers words that produce no result but may still be in flight.
  localparam int IDLE_PAD = 6;
  localparam int PHASE_ITEMS = 64;

  // Ways in which the stimulus breaks an otherwise well-formed fragment.
  typedef enum int {
    FLT_NONE,
    FLT_SHORT,
    FLT_BAD_HDR,
    FLT_DUP,
    FLT_SKIP,
    FLT_COUNT,
    FLT_BIG
  } fault_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        timeout_we = 1'b0;
  logic [31:0] timeout_wdata = '0;

  // Scoreboard: tracks the reassembly state word by word and keeps the
  // results that the accepted words must produce, oldest first.
  class reassembly_scoreboard;
    bit [7:0]  store [REC_MAX];
    bit        written [REC_MAX];
    int        written_idx [$];
    bit [9:0]  rec_len;
    bit [7:0]  open_id;
    bit [7:0]  open_total;
    bit [7:0]  next_idx;
    bit [9:0]  first_size;
    bit [31:0] start_ms;
    bit        busy;
    bit [10:0] pos;
    bit [7:0]  hdr_id;
    bit [7:0]  hdr_idx;
    bit [7:0]  hdr_total;
    bit [31:0] timeout_ms = 32'd5000;
    result_t   expected [$];
    int        errors;
    int        results_seen;
    int        status_seen [8];

    function void drop_message();
      rec_len = '0;
      open_id = '0;
      open_total = '0;
      next_idx = '0;
      first_size = '0;
      start_ms = '0;
      busy = 1'b0;
    endfunction

    function status_t reject(status_t code);
      drop_message();
      return code;
    endfunction

    // Decide the status of a fragment whose last byte just arrived.
    function status_t judge_fragment(int flen, bit [31:0] stamp, output rlen_t len);
      int plen;
      len = '0;
      if (flen < HDR_BYTES || hdr_total == 0 || hdr_idx >= hdr_total)
        return reject(ST_BAD_HEADER);
      plen = flen - HDR_BYTES;
      if (!busy || hdr_id != open_id) begin
        // A fragment for a message that is not open must start it.
        if (hdr_idx != 0)
          return reject(ST_OUT_OF_ORDER);
        if (plen > REC_MAX || (int'(hdr_total) - 1) * plen >= REC_MAX)
          return reject(ST_OVERSIZED);
        rec_len = 10'(plen);
        open_id = hdr_id;
        open_total = hdr_total;
        first_size = 10'(plen);
        next_idx = 8'd1;
        start_ms = stamp;
        busy = 1'b1;
      end else begin
        if (hdr_idx < next_idx)
          return reject(ST_DUPLICATE);
        if (hdr_idx > next_idx)
          return reject(ST_OUT_OF_ORDER);
        if (hdr_total != open_total)
          return reject(ST_COUNT_MISMATCH);
        if (plen > int'(first_size) || int'(rec_len) + plen > REC_MAX)
          return reject(ST_OVERSIZED);
        rec_len = 10'(int'(rec_len) + plen);
        next_idx = hdr_idx + 8'd1;
      end
      if (next_idx == open_total) begin
        len = rec_len;
        drop_message();
        return ST_COMPLETE;
      end
      return ST_OK;
    endfunction

    function void note_item(item_t it);
      result_t want;
      bit      answers;
      int      cnt;
      int      addr;
      rlen_t   len;
      bit [31:0] age;
      want = '0;
      answers = 1'b0;
      case (it.kind)
        KIND_FRAG: begin
          if (pos == 1) begin
            hdr_id = it.data_byte;
          end else if (pos == 2) begin
            hdr_idx = it.data_byte;
          end else if (pos == 3) begin
            hdr_total = it.data_byte;
          end else if (pos >= HDR_BYTES) begin
            // Payload lands behind the open record only if the header continues it.
            addr = ((busy && hdr_id == open_id) ? int'(rec_len) : 0) + int'(pos) - HDR_BYTES;
            if (addr < REC_MAX) begin
              store[addr] = it.data_byte;
              if (!written[addr]) begin
                written[addr] = 1'b1;
                written_idx.push_back(addr);
              end
            end
          end
          cnt = (pos < POS_SAT) ? int'(pos) + 1 : POS_SAT;
          if (!it.frag_last) begin
            pos = 11'(cnt);
          end else begin
            pos = '0;
            want.status = judge_fragment(cnt, it.now_ms, len);
            want.record_length = len;
            answers = 1'b1;
          end
        end
        KIND_CHECK: begin
          answers = 1'b1;
          age = it.now_ms - start_ms;
          if (busy && age > timeout_ms) begin
            drop_message();
            want.status = ST_TIMEOUT;
          end
        end
        KIND_READ: begin
          answers = 1'b1;
          if (it.read_index < REC_MAX)
            want.read_byte = store[it.read_index];
        end
        default: ;
      endcase
      if (answers)
        expected.push_back(want);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing pending, expected none, actual status %0d",
                 $time, got.status);
        return;
      end
      want = expected.pop_front();
      status_seen[int'(want.status)]++;
      if (got.status !== want.status)
        report_field("status", 32'(want.status), 32'(got.status));
      if (got.record_length !== want.record_length)
        report_field("record_length", 32'(want.record_length), 32'(got.record_length));
      if (got.read_byte !== want.read_byte)
        report_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
    endfunction
  endclass

  reassembly_scoreboard sb;

  int        items_sent = 0;
  int        quiet_cycles = 0;
  int        stall_hold = 0;
  int        roll;
  bit        calm = 1'b0;        // no gaps and no stalls while set
  bit        interleave = 1'b0;  // mix checks and reads into fragment streams
  bit [31:0] now_t = '0;         // running millisecond clock of the stimulus

  in_order_fragment_reassembler #(
    .MAX_RECORD(REC_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .timeout_we(timeout_we),
    .timeout_wdata(timeout_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver side. The stall is redrawn at falling edges: mostly free-running,
  // sometimes short stalls, and now and then a long one. While the stimulus is
  // calm the receiver stops stalling once any running hold ends.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (calm) begin
      result_stall = 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        result_stall = 1'b0;
        stall_hold = $urandom_range(0, 8);
      end else if (roll < 93) begin
        result_stall = 1'b1;
        stall_hold = $urandom_range(0, 3);
      end else begin
        result_stall = 1'b1;
        stall_hold = $urandom_range(6, 30);
      end
    end
  end

  // Every result word accepted at a rising edge is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(result);
  end

  // The watchdog ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles, %0d results still pending",
                 quiet_cycles, sb.expected.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Sender gap before a word: usually none, sometimes a few cycles, rarely long.
  function int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // A word of the given kind with every other field random, so that unused
  // fields see both values of every bit.
  function item_t noise_item(logic [1:0] k);
    item_t it;
    it.kind = k;
    it.data_byte = 8'($urandom);
    it.frag_last = 1'($urandom);
    it.now_ms = $urandom;
    it.read_index = 10'($urandom);
    return it;
  endfunction

  function void advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      now_t = $urandom;
    else if (r < 4)
      now_t = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else if (r < 9)
      now_t += $urandom_range(0, 100000);
    else
      now_t += $urandom_range(0, 40);
  endfunction

  // Check times cluster around the open message's deadline so that the
  // boundary between keeping and dropping it is hit often.
  function bit [31:0] pick_check_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return now_t + $urandom_range(0, 30);
    if (r < 70)
      return sb.start_ms + sb.timeout_ms + $urandom_range(0, 2) - 1;
    if (r < 85)
      return now_t + $urandom_range(0, 20000);
    return $urandom;
  endfunction

  // Reads go to bytes that were written at some point, or past the end of the
  // store; a byte that was never written is never read.
  function ridx_t pick_read_index();
    if (sb.written_idx.size() > 0 && $urandom_range(0, 9) != 0)
      return ridx_t'(sb.written_idx[$urandom_range(0, sb.written_idx.size() - 1)]);
    return ridx_t'($urandom_range(REC_MAX, 1023));
  endfunction

  function fault_e pick_fault();
    if ($urandom_range(0, 99) < 88)
      return FLT_NONE;
    case ($urandom_range(0, 5))
      0: return FLT_SHORT;
      1: return FLT_BAD_HDR;
      2: return FLT_DUP;
      3: return FLT_SKIP;
      4: return FLT_COUNT;
      default: return FLT_BIG;
    endcase
  endfunction

  // Offers one word and holds it until the block takes it. Called and left at
  // a falling edge; the scoreboard hears of the word at the falling edge after the
  // edge that accepted it, so it never races with the result checker.
  task automatic push_item(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do
      @(posedge clk);
    while (item_stall);
    @(negedge clk);
    item_valid = 1'b0;
    sb.note_item(it);
    if (it.kind != KIND_IGNORED)
      items_sent++;
  endtask

  // A timeout check, a record read or a meaningless word.
  task automatic send_side();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it = noise_item(KIND_CHECK);
      it.now_ms = pick_check_time();
    end else if (r < 92) begin
      it = noise_item(KIND_READ);
      it.read_index = pick_read_index();
    end else begin
      it = noise_item(KIND_IGNORED);
    end
    push_item(it);
  endtask

  // Sends one fragment of nbytes bytes: flags, id, index, count, then payload.
  // The time stamp rides on the last byte; other bytes carry random time.
  task automatic send_raw(int nbytes, bit [7:0] id, bit [7:0] idx, bit [7:0] tot,
                          bit [31:0] stamp);
    item_t it;
    for (int k = 0; k < nbytes; k++) begin
      if (interleave && $urandom_range(0, 99) < 3)
        send_side();
      it = noise_item(KIND_FRAG);
      case (k)
        1: it.data_byte = id;
        2: it.data_byte = idx;
        3: it.data_byte = tot;
        default: ;
      endcase
      it.frag_last = (k == nbytes - 1);
      if (it.frag_last)
        it.now_ms = stamp;
      push_item(it);
    end
  endtask

  // One message as a sender would build it, possibly broken by one fault or
  // abandoned part way. A forced length sends a single clean fragment of that
  // payload size, here used for a fragment past the limit.
  task automatic send_message(int forced_len);
    bit [7:0] id;
    bit [7:0] idx;
    bit [7:0] tot;
    int       r;
    int       total;
    int       maxp;
    int       cap;
    int       p;
    int       len;
    int       rec;
    fault_e   fault;
    // A few ids are reused a lot so that fresh messages collide with open ones.
    id = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    r = $urandom_range(0, 99);
    total = (r < 35) ? 1 : (r < 75) ? $urandom_range(2, 4) :
            (r < 95) ? $urandom_range(5, 12) : $urandom_range(13, 255);
    maxp = (total == 1) ? REC_MAX : (REC_MAX - 1) / (total - 1);
    r = $urandom_range(0, 99);
    cap = (r < 70) ? 8 : (r < 95) ? 40 : maxp;
    p = $urandom_range(0, (maxp < cap) ? maxp : cap);
    if (forced_len >= 0) begin
      total = 1;
      p = forced_len;
    end
    rec = 0;
    for (int i = 0; i < total; i++) begin
      fault = (forced_len >= 0) ? FLT_NONE : pick_fault();
      advance_clock();
      if (interleave && $urandom_range(0, 99) < 10)
        send_side();
      if (i > 0 && ($urandom_range(0, 99) < 4 || (total > 12 && i >= 3)))
        return;
      idx = 8'(i);
      tot = 8'(total);
      len = (i == 0) ? p : $urandom_range(0, (p < REC_MAX - rec) ? p : REC_MAX - rec);
      case (fault)
        FLT_SHORT: begin
          send_raw($urandom_range(1, HDR_BYTES - 1), id, idx, tot, now_t);
          return;
        end
        FLT_BAD_HDR: begin
          if ($urandom_range(0, 1))
            tot = '0;
          else
            idx = 8'($urandom_range(total, 255));
        end
        FLT_DUP: idx = (i == 0) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(0, i - 1));
        FLT_SKIP: idx = 8'(i + $urandom_range(1, 3));
        FLT_COUNT: tot = 8'(total + $urandom_range(1, 5));
        FLT_BIG: len = ((i == 0) ? maxp : p) + $urandom_range(1, 10);
        default: ;
      endcase
      send_raw(HDR_BYTES + len, id, idx, tot, now_t);
      if (fault != FLT_NONE)
        return;
      rec += len;
    end
  endtask

  // Stops sending and lets every pending result come out, plus a pad for
  // words that produce nothing but may still be inside the block.
  task automatic wait_drained();
    item_valid = 1'b0;
    while (sb.expected.size() != 0)
      @(negedge clk);
    repeat (IDLE_PAD) @(negedge clk);
  endtask

  // The timeout register is only written while the block is quiet.
  task automatic write_timeout(bit [31:0] value);
    wait_drained();
    timeout_we = 1'b1;
    timeout_wdata = value;
    @(negedge clk);
    timeout_we = 1'b0;
    sb.timeout_ms = value;
  endtask

  // Random traffic: mostly whole messages with random content, some loose
  // checks and reads. Halfway through, the sender waits for all results.
  task automatic run_random(int target);
    int start;
    bit paused;
    start = items_sent;
    paused = 1'b0;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 99) < 6)
        calm = ~calm;
      if (!paused && items_sent - start >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 10)
        send_side();
      else
        send_message(-1);
    end
    calm = 1'b0;
  endtask

  initial begin
    item_t it;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the timeout at its reset value of 5000 ms.
    now_t = 32'd1000;
    send_raw(2, 8'd1, 8'd0, 8'd1, now_t);            // fragment cut inside its header
    send_raw(HDR_BYTES, 8'd1, 8'd0, 8'd0, now_t);    // count of zero
    send_raw(HDR_BYTES, 8'd1, 8'd3, 8'd3, now_t);    // index equal to the count
    send_raw(HDR_BYTES, 8'hFF, 8'd0, 8'd1, now_t);   // whole message, empty record
    it = noise_item(KIND_READ);
    it.read_index = 10'h3FF;                         // past the end of the store
    push_item(it);
    it = noise_item(KIND_IGNORED);
    push_item(it);
    it = noise_item(KIND_CHECK);                     // nothing open, nothing to drop
    push_item(it);
    // Open a message just before the clock wraps, then check exactly at the
    // deadline (kept) and one millisecond later (dropped).
    now_t = 32'hFFFF_FFF0;
    send_raw(HDR_BYTES + 1, 8'd2, 8'd0, 8'd2, now_t);
    it = noise_item(KIND_CHECK);
    it.now_ms = now_t + sb.timeout_ms;
    push_item(it);
    it.now_ms = it.now_ms + 32'd1;
    push_item(it);
    it = noise_item(KIND_READ);
    it.read_index = '0;
    push_item(it);

    interleave = 1'b1;
    run_random(PHASE_ITEMS);
    // A fragment long enough to saturate the byte counter; its tail runs
    // past the end of the store.
    send_message(790);

    write_timeout(32'd0);
    run_random(PHASE_ITEMS);
    write_timeout(32'hFFFF_FFFF);
    run_random(PHASE_ITEMS);
    write_timeout($urandom);
    run_random(PHASE_ITEMS);
    write_timeout($urandom_range(1, 3000));
    run_random(PHASE_ITEMS);

    wait_drained();
    $display("Sent %0d words and checked %0d results: %0d records completed, %0d timeouts.",
             items_sent, sb.results_seen, sb.status_seen[ST_COMPLETE],
             sb.status_seen[ST_TIMEOUT]);
    $display("Rejections: bad header %0d, out of order %0d, duplicate %0d, count %0d, size %0d.",
             sb.status_seen[ST_BAD_HEADER], sb.status_seen[ST_OUT_OF_ORDER],
             sb.status_seen[ST_DUPLICATE], sb.status_seen[ST_COUNT_MISMATCH],
             sb.status_seen[ST_OVERSIZED]);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ofr_pkg.sv
rtl/ofr_ram.sv
rtl/in_order_fragment_reassembler.sv
tb/sv/in_order_fragment_reassembler_tb.sv
